### hw/rtl/chacha20_stream_xor_macros.svh
// assertion helpers used by the checker of this block
`ifndef CHACHA20_STREAM_XOR_MACROS_SVH
`define CHACHA20_STREAM_XOR_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define CC20_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: check failed");

// next-cycle implication, disabled while reset is low
`define CC20_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: check failed");

`endif

### hw/rtl/cc20_pkg.sv
`timescale 1ns / 1ps

package cc20_pkg;

    localparam int DOUBLE_ROUNDS = 10;
    localparam int DR_W          = (DOUBLE_ROUNDS > 1) ? $clog2(DOUBLE_ROUNDS) : 1;

    localparam int KS_WORDS = 16;
    localparam int KS_AW    = $clog2(KS_WORDS);

    localparam logic [31:0] SIGMA_0 = 32'h6170_7865;
    localparam logic [31:0] SIGMA_1 = 32'h3320_646e;
    localparam logic [31:0] SIGMA_2 = 32'h7962_2d32;
    localparam logic [31:0] SIGMA_3 = 32'h6b20_6574;

    // config register indexes
    localparam int          CFG_IDX_W  = 3;
    localparam logic [2:0]  CFG_KEY_A  = 3'd0;
    localparam logic [2:0]  CFG_KEY_B  = 3'd1;
    localparam logic [2:0]  CFG_KEY_C  = 3'd2;
    localparam logic [2:0]  CFG_KEY_D  = 3'd3;
    localparam logic [2:0]  CFG_NONCE_LO = 3'd4;
    localparam logic [2:0]  CFG_NONCE_HI = 3'd5;
    localparam logic [2:0]  CFG_START  = 3'd6;

    localparam logic [31:0] START_RESET = 32'd1;

    // rotate amounts of the quarter-round sub-steps
    localparam logic [1:0] ROT_16 = 2'd0;
    localparam logic [1:0] ROT_12 = 2'd1;
    localparam logic [1:0] ROT_8  = 2'd2;
    localparam logic [1:0] ROT_7  = 2'd3;

    typedef logic [KS_WORDS-1:0][31:0] t_words;
    typedef logic [3:0][63:0]          t_key;

    typedef struct packed {
        logic [7:0] data_in;
        logic       end_of_message;
    } t_in_item;

    typedef struct packed {
        logic [7:0] data_out;
        logic       out_last;
    } t_out_item;

    typedef struct packed {
        logic             we;
        logic [KS_AW-1:0] addr;
        logic [31:0]      data;
    } t_ram_wr;

    function automatic t_words cc20_init(input t_key key, input logic [63:0] nonce_lo,
                                         input logic [31:0] nonce_hi,
                                         input logic [31:0] ctr);
        t_words w;
        w[0]  = SIGMA_0;
        w[1]  = SIGMA_1;
        w[2]  = SIGMA_2;
        w[3]  = SIGMA_3;
        w[4]  = key[0][31:0];
        w[5]  = key[0][63:32];
        w[6]  = key[1][31:0];
        w[7]  = key[1][63:32];
        w[8]  = key[2][31:0];
        w[9]  = key[2][63:32];
        w[10] = key[3][31:0];
        w[11] = key[3][63:32];
        w[12] = ctr;
        w[13] = nonce_lo[31:0];
        w[14] = nonce_lo[63:32];
        w[15] = nonce_hi;
        return w;
    endfunction

endpackage

### hw/rtl/cc20_ram.sv
`timescale 1ns / 1ps

module cc20_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### hw/rtl/cc20_qr.sv
`timescale 1ns / 1ps

// one quarter-round sub-step: x + y, then (z ^ sum) rotated left
module cc20_qr (
    input  logic [31:0] i_x,
    input  logic [31:0] i_y,
    input  logic [31:0] i_z,
    input  logic [1:0]  i_rot,
    output logic [31:0] o_sum,
    output logic [31:0] o_mix
);
    import cc20_pkg::*;

    logic [31:0] mixed;

    assign o_sum = i_x + i_y;
    assign mixed = i_z ^ o_sum;

    always_comb begin
        unique case (i_rot)
            ROT_16:  o_mix = {mixed[15:0], mixed[31:16]};
            ROT_12:  o_mix = {mixed[19:0], mixed[31:20]};
            ROT_8:   o_mix = {mixed[23:0], mixed[31:24]};
            ROT_7:   o_mix = {mixed[24:0], mixed[31:25]};
            default: o_mix = mixed;
        endcase
    end

endmodule

### hw/rtl/cc20_core.sv
`timescale 1ns / 1ps

module cc20_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  cc20_pkg::t_words i_init,
    output cc20_pkg::t_ram_wr o_ram_wr,
    output logic             o_done
);
    import cc20_pkg::*;

    localparam logic [1:0] CS_IDLE  = 2'd0;
    localparam logic [1:0] CS_ROUND = 2'd1;
    localparam logic [1:0] CS_FINAL = 2'd2;

    logic [1:0]       r_state, n_state;
    logic [1:0]       r_sub;
    logic [2:0]       r_qr;
    logic [DR_W-1:0]  r_dr;
    logic [KS_AW-1:0] r_k;
    logic             r_done;
    t_words           r_w, n_w;

    logic        diag;
    logic [31:0] qr_x, qr_y, qr_z, qr_sum, qr_mix;
    logic [1:0]  qr_rot;
    t_words      upd;

    cc20_qr u_qr (
        .i_x   (qr_x),
        .i_y   (qr_y),
        .i_z   (qr_z),
        .i_rot (qr_rot),
        .o_sum (qr_sum),
        .o_mix (qr_mix)
    );

    // rows rotate after each quarter round, so the taps stay fixed:
    // column round uses 0/4/8/12, diagonal round 0/5/10/15
    assign diag = r_qr[2];

    always_comb begin
        qr_x   = r_w[0];
        qr_y   = i_init[r_k];
        qr_z   = diag ? r_w[15] : r_w[12];
        qr_rot = ROT_16;
        upd    = r_w;
        if (r_state == CS_ROUND) begin
            unique case (r_sub)
                2'd0, 2'd2: begin
                    qr_x   = r_w[0];
                    qr_y   = diag ? r_w[5] : r_w[4];
                    qr_z   = diag ? r_w[15] : r_w[12];
                    qr_rot = (r_sub == 2'd0) ? ROT_16 : ROT_8;
                    upd[0] = qr_sum;
                    if (diag) begin
                        upd[15] = qr_mix;
                    end else begin
                        upd[12] = qr_mix;
                    end
                end
                default: begin
                    qr_x   = diag ? r_w[10] : r_w[8];
                    qr_y   = diag ? r_w[15] : r_w[12];
                    qr_z   = diag ? r_w[5] : r_w[4];
                    qr_rot = (r_sub == 2'd1) ? ROT_12 : ROT_7;
                    if (diag) begin
                        upd[10] = qr_sum;
                        upd[5]  = qr_mix;
                    end else begin
                        upd[8]  = qr_sum;
                        upd[4]  = qr_mix;
                    end
                end
            endcase
        end
    end

    always_comb begin
        n_state = r_state;
        n_w     = r_w;
        unique case (r_state)
            CS_IDLE: begin
                if (i_start) begin
                    n_w     = i_init;
                    n_state = CS_ROUND;
                end
            end
            CS_ROUND: begin
                if (r_sub == 2'd3) begin
                    // rotate each row left by one word
                    for (int r = 0; r < 4; r++) begin
                        for (int j = 0; j < 4; j++) begin
                            n_w[4*r+j] = upd[4*r+((j+1)%4)];
                        end
                    end
                    if (r_qr == 3'd7 && r_dr == DR_W'(DOUBLE_ROUNDS - 1)) begin
                        n_state = CS_FINAL;
                    end
                end else begin
                    n_w = upd;
                end
            end
            CS_FINAL: begin
                for (int i = 0; i < KS_WORDS; i++) begin
                    n_w[i] = r_w[(i+1)%KS_WORDS];
                end
                if (r_k == KS_AW'(KS_WORDS - 1)) begin
                    n_state = CS_IDLE;
                end
            end
            default: n_state = CS_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= CS_IDLE;
            r_sub   <= '0;
            r_qr    <= '0;
            r_dr    <= '0;
            r_k     <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == CS_FINAL) && (n_state == CS_IDLE);
            if (r_state == CS_IDLE) begin
                r_sub <= '0;
                r_qr  <= '0;
                r_dr  <= '0;
                r_k   <= '0;
            end else if (r_state == CS_ROUND) begin
                r_sub <= r_sub + 2'd1;
                if (r_sub == 2'd3) begin
                    r_qr <= r_qr + 3'd1;
                    if (r_qr == 3'd7) begin
                        r_dr <= r_dr + DR_W'(1);
                    end
                end
            end else begin
                r_k <= r_k + KS_AW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_w <= n_w;
    end

    assign o_ram_wr.we   = (r_state == CS_FINAL);
    assign o_ram_wr.addr = r_k;
    assign o_ram_wr.data = qr_sum;
    assign o_done        = r_done;

endmodule

### hw/rtl/chacha20_stream_xor.sv
`timescale 1ns / 1ps
// chacha20 stream xor, one byte per item
// buffered byte: accept, then xor into the output register; the input stalls until the result is registered
// first byte of a block: 320 sub-steps of the shared adder, 16 final adds, done, ram read, xor,
// output; the later bytes of the block use the held keystream
// synchronous active-low reset: key and nonce 0, start counter 1, no keystream held

module chacha20_stream_xor (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // input channel
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  cc20_pkg::t_in_item                   i_in_data,
    // output channel
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output cc20_pkg::t_out_item                  o_out_data,
    // config write port
    input  logic                                 i_cfg_we,
    input  logic [cc20_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [63:0]                          i_cfg_data
);
    import cc20_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;   // waiting for an item
    localparam logic [1:0] ST_GEN  = 2'd1;   // keystream block in progress
    localparam logic [1:0] ST_READ = 2'd2;   // ram read of the current word
    localparam logic [1:0] ST_XOR  = 2'd3;   // combine and hand to the output register

    // config registers
    t_key        r_key;
    logic [63:0] r_nonce_lo;
    logic [31:0] r_nonce_hi;
    logic [31:0] r_start_ctr;

    // running state
    logic [31:0] r_counter;
    logic [5:0]  r_pos;
    logic        r_ready;
    logic [1:0]  r_state, n_state;

    // held item and output register
    t_in_item    r_in;
    t_out_item   r_out;
    logic        r_out_valid;

    logic        in_fire;
    logic        cfg_hit;
    logic        xor_fire;
    logic        gen_start;
    logic        gen_done;
    logic        blk_end;
    t_words      init_words;
    t_ram_wr     ram_wr;
    logic [31:0] ks_word;
    logic [7:0]  ks_byte;

    assign o_in_stall = (r_state != ST_IDLE);
    assign in_fire    = i_in_valid && !o_in_stall;
    assign cfg_hit    = i_cfg_we && (i_cfg_index <= CFG_START);
    // the output register is free when empty or being drained this cycle
    assign xor_fire   = (r_state == ST_XOR) && (!r_out_valid || !i_out_stall);
    assign gen_start  = in_fire && !r_ready;
    // counter moves on after the last byte of a block or of a message
    assign blk_end    = r_in.end_of_message || (r_pos == 6'd63);

    assign init_words = cc20_init(r_key, r_nonce_lo, r_nonce_hi, r_counter);

    cc20_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (gen_start),
        .i_init   (init_words),
        .o_ram_wr (ram_wr),
        .o_done   (gen_done)
    );

    // keystream block held as 16 words, read at the word of the current byte
    cc20_ram #(
        .WIDTH (32),
        .DEPTH (KS_WORDS)
    ) u_ks_ram (
        .i_clk   (i_clk),
        .i_we    (ram_wr.we),
        .i_waddr (ram_wr.addr),
        .i_wdata (ram_wr.data),
        .i_raddr (r_pos[5:2]),
        .o_rdata (ks_word)
    );

    assign ks_byte = ks_word[8*r_pos[1:0] +: 8];

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    n_state = r_ready ? ST_XOR : ST_GEN;
                end
            end
            ST_GEN: begin
                if (gen_done) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: n_state = ST_XOR;
            ST_XOR: begin
                if (xor_fire) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_key       <= '0;
            r_nonce_lo  <= '0;
            r_nonce_hi  <= '0;
            r_start_ctr <= START_RESET;
            r_counter   <= START_RESET;
            r_pos       <= '0;
            r_ready     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;

            if (cfg_hit) begin
                unique case (i_cfg_index)
                    CFG_KEY_A:    r_key[0]    <= i_cfg_data;
                    CFG_KEY_B:    r_key[1]    <= i_cfg_data;
                    CFG_KEY_C:    r_key[2]    <= i_cfg_data;
                    CFG_KEY_D:    r_key[3]    <= i_cfg_data;
                    CFG_NONCE_LO: r_nonce_lo  <= i_cfg_data;
                    CFG_NONCE_HI: r_nonce_hi  <= i_cfg_data[31:0];
                    CFG_START:    r_start_ctr <= i_cfg_data[31:0];
                    default: ;
                endcase
                // any write to a config register restarts from the start counter with no block held
                r_counter <= (i_cfg_index == CFG_START) ? i_cfg_data[31:0] : r_start_ctr;
                r_pos     <= '0;
                r_ready   <= 1'b0;
            end else if (xor_fire) begin
                if (blk_end) begin
                    r_counter <= r_counter + 32'd1;
                    r_pos     <= '0;
                    r_ready   <= 1'b0;
                end else begin
                    r_pos <= r_pos + 6'd1;
                end
            end else if (gen_done) begin
                r_ready <= 1'b1;
            end

            if (xor_fire) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_in <= i_in_data;
        end
        if (xor_fire) begin
            r_out.data_out <= r_in.data_in ^ ks_byte;
            r_out.out_last <= r_in.end_of_message;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

### hw/rtl/cc20_checker.sv
`timescale 1ns / 1ps
`include "chacha20_stream_xor_macros.svh"

module cc20_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_in_valid,
    input logic                           o_in_stall,
    input cc20_pkg::t_in_item             i_in_data,
    input logic                           o_out_valid,
    input logic                           i_out_stall,
    input cc20_pkg::t_out_item            o_out_data,
    input logic                           i_cfg_we,
    input logic [cc20_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input logic [63:0]                    i_cfg_data
);
    import cc20_pkg::*;

    logic in_fire;
    logic unused_ports;

    assign in_fire      = i_in_valid && !o_in_stall;
    assign unused_ports = ^{i_in_data, i_cfg_we, i_cfg_index, i_cfg_data};

    // a held result stays until taken
    `CC20_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid)
    `CC20_ASSERT_NXT(a_out_stable, i_clk, i_rst_n, o_out_valid && i_out_stall, $stable(o_out_data))
    // one item at a time: busy right after an accept
    `CC20_ASSERT_NXT(a_busy_after_accept, i_clk, i_rst_n, in_fire, o_in_stall)
    // a new result only comes out of a busy cycle, and frees the input side
    `CC20_ASSERT_IMP(a_result_from_busy, i_clk, i_rst_n, $rose(o_out_valid), $past(o_in_stall))
    `CC20_ASSERT_IMP(a_idle_after_result, i_clk, i_rst_n, $rose(o_out_valid), !o_in_stall)

endmodule

bind chacha20_stream_xor cc20_checker u_checker (.*);
